// ===== rtl/tmc_pkg.sv =====
// Shared constants, types and structs of the tile map collision mover.
package tmc_pkg;

  localparam int TILE_SIZE  = 80;
  localparam int MAP_COLS   = 16;
  localparam int MAP_ROWS   = 12;
  localparam int DOT_SIZE   = 20;
  localparam int CELL_COUNT = MAP_COLS * MAP_ROWS;
  localparam int TYPE_COUNT = 12;
  localparam int VEL_LIMIT  = 63;
  localparam int LEVEL_W    = MAP_COLS * TILE_SIZE;
  localparam int LEVEL_H    = MAP_ROWS * TILE_SIZE;

  localparam int POS_W  = 11;
  localparam int POSY_W = 10;
  localparam int VEL_W  = 7;
  localparam int CELL_W = 8;
  localparam int TYPE_W = 4;
  localparam int MAP_MAX = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;
  localparam int QW = $clog2(MAP_MAX + 1);

  // Division by the tile size as a multiply by a rounded-up reciprocal.
  localparam int DIV_SHIFT = POS_W + $clog2(TILE_SIZE);
  localparam int DIV_RECIP = ((2 ** DIV_SHIFT) + TILE_SIZE - 1) / TILE_SIZE;
  localparam int PROD_W = POS_W + DIV_SHIFT + 1;

  localparam logic [1:0] KIND_TILE = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] KEY_UP    = 2'd0;
  localparam logic [1:0] KEY_DOWN  = 2'd1;
  localparam logic [1:0] KEY_LEFT  = 2'd2;
  localparam logic [1:0] KEY_RIGHT = 2'd3;

  typedef struct packed {
    logic [4:0]  velocity_step;
    logic [10:0] view_width;
    logic [9:0]  view_height;
    logic [3:0]  wall_first_type;
    logic [3:0]  wall_last_type;
  } tmc_cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CELL_W-1:0] tile_index;
    logic [TYPE_W-1:0] tile_type;
    logic [1:0]        key_code;
    logic              key_down;
    logic              key_repeat;
  } tmc_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  dot_x;
    logic [POSY_W-1:0] dot_y;
    logic [POS_W-1:0]  camera_x;
    logic [POSY_W-1:0] camera_y;
    logic              x_blocked;
    logic              y_blocked;
    logic              tile_rejected;
  } tmc_res_t;

endpackage

// ===== rtl/tmc_map_ram.sv =====
// Simple dual-port tile map memory with a registered read port.
module tmc_map_ram #(
  parameter int DEPTH = 192,
  parameter int AW = 8,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tmc_tile_div.sv =====
// Tile coordinate of a pixel coordinate: division by the tile size.
module tmc_tile_div (
  input  logic [tmc_pkg::POS_W-1:0] num,
  output logic [tmc_pkg::QW-1:0]    quo
);
  import tmc_pkg::*;

  logic [PROD_W-1:0] prod;

  always_comb begin
    prod = PROD_W'(num) * PROD_W'(DIV_RECIP);
    quo  = QW'(prod >> DIV_SHIFT);
  end

endmodule

// ===== rtl/tmc_mover.sv =====
// Sequencer for tile writes, key events and movement ticks around the map memory.
module tmc_mover (
  input  logic              clk,
  input  logic              rst,
  input  tmc_pkg::tmc_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  tmc_pkg::tmc_in_t  in_item,
  output logic              res_valid,
  input  logic              res_ready,
  output tmc_pkg::tmc_res_t res
);
  import tmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_AXIS, S_Q0, S_Q1, S_Q2, S_Q3, S_READ, S_DRAIN, S_APPLY, S_CAM, S_OUT
  } state_t;

  localparam logic signed [12:0] LEVEL_W_S = 13'(LEVEL_W);
  localparam logic signed [12:0] LEVEL_H_S = 13'(LEVEL_H);
  localparam logic signed [12:0] DOT_S     = 13'(DOT_SIZE);

  state_t                state;
  logic [POS_W-1:0]      pos_x;
  logic [POSY_W-1:0]     pos_y;
  logic signed [VEL_W-1:0] vel_x, vel_y;
  logic                  axis_y;
  logic [POS_W-1:0]      cand;
  logic [POS_W-1:0]      fixed_c;
  logic [QW-1:0]         qa0, qa1, qb0, qb1;
  logic                  oob, hit, x_blk, rd_live;
  logic [1:0]            rd_cnt;

  logic signed [12:0]    cand_n;
  logic                  cand_oob;
  logic [POS_W-1:0]      div_num;
  logic [QW-1:0]         div_quo;
  logic [QW-1:0]         row_sel, col_sel;
  logic [CELL_W-1:0]     rd_addr;
  logic [TYPE_W-1:0]     rd_data;
  logic                  is_wall;
  logic                  tile_bad;
  logic                  accept;
  logic signed [7:0]     step_s, vel_x_next, vel_y_next;

  function automatic logic signed [VEL_W-1:0] sat_vel(logic signed [7:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > 8'sd63) begin
      r = 7'sd63;
    end else if (v < -8'sd63) begin
      r = -7'sd63;
    end else begin
      r = VEL_W'(v);
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] cam_edge(logic [POS_W-1:0] pos,
                                                logic [POS_W-1:0] view,
                                                logic signed [13:0] level);
    logic signed [13:0] c;
    logic signed [13:0] lv;
    c  = $signed({3'b0, pos}) + 14'(DOT_SIZE / 2) - $signed({4'b0, view[POS_W-1:1]});
    lv = level - $signed({3'b0, view});
    if (c < 0) begin
      c = '0;
    end
    if (c > lv) begin
      c = lv;
    end
    if (c < 0) begin
      c = '0;
    end
    return POS_W'(c);
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE) && !rst;
  assign res_valid = (state == S_OUT);

  always_comb begin
    if (axis_y) begin
      cand_n   = 13'($signed({1'b0, pos_y})) + 13'(vel_y);
      cand_oob = (cand_n < 0) || ((cand_n + DOT_S) > LEVEL_H_S);
    end else begin
      cand_n   = 13'($signed({1'b0, pos_x})) + 13'(vel_x);
      cand_oob = (cand_n < 0) || ((cand_n + DOT_S) > LEVEL_W_S);
    end
  end

  always_comb begin
    case (state)
      S_Q0:    div_num = cand;
      S_Q1:    div_num = cand + POS_W'(DOT_SIZE - 1);
      S_Q2:    div_num = fixed_c;
      S_Q3:    div_num = fixed_c + POS_W'(DOT_SIZE - 1);
      default: div_num = cand;
    endcase
  end

  tmc_tile_div u_div (
    .num (div_num),
    .quo (div_quo)
  );

  // Up to four cells: top-left, top-right, bottom-left, bottom-right of the mover.
  always_comb begin
    logic [QW-1:0] a_sel, b_sel;
    a_sel = (axis_y ? rd_cnt[1] : rd_cnt[0]) ? qa1 : qa0;
    b_sel = (axis_y ? rd_cnt[0] : rd_cnt[1]) ? qb1 : qb0;
    row_sel = axis_y ? a_sel : b_sel;
    col_sel = axis_y ? b_sel : a_sel;
    rd_addr = CELL_W'(row_sel * MAP_COLS) + CELL_W'(col_sel);
  end

  assign tile_bad = (in_item.tile_type >= TYPE_W'(TYPE_COUNT)) ||
                    (in_item.tile_index >= CELL_W'(CELL_COUNT));

  tmc_map_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (CELL_W),
    .DW    (TYPE_W)
  ) u_map (
    .clk   (clk),
    .we    (accept && (in_item.kind == KIND_TILE) && !tile_bad),
    .waddr (in_item.tile_index),
    .wdata (in_item.tile_type),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign is_wall = (rd_data >= cfg.wall_first_type) && (rd_data <= cfg.wall_last_type);

  always_comb begin
    step_s = in_item.key_down ? $signed({3'b0, cfg.velocity_step})
                              : -$signed({3'b0, cfg.velocity_step});
    vel_x_next = 8'(vel_x);
    vel_y_next = 8'(vel_y);
    case (in_item.key_code)
      KEY_UP:    vel_y_next = 8'(vel_y) - step_s;
      KEY_DOWN:  vel_y_next = 8'(vel_y) + step_s;
      KEY_LEFT:  vel_x_next = 8'(vel_x) - step_s;
      default:   vel_x_next = 8'(vel_x) + step_s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos_x   <= '0;
      pos_y   <= '0;
      vel_x   <= '0;
      vel_y   <= '0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= (state == S_READ);
      if (rd_live && is_wall) begin
        hit <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_item.kind)
              KIND_TILE: begin
                res   <= '{dot_x: '0, dot_y: '0, camera_x: '0, camera_y: '0,
                           x_blocked: 1'b0, y_blocked: 1'b0, tile_rejected: tile_bad};
                state <= S_OUT;
              end
              KIND_KEY: begin
                if (!in_item.key_repeat) begin
                  vel_x <= sat_vel(vel_x_next);
                  vel_y <= sat_vel(vel_y_next);
                end
              end
              KIND_TICK: begin
                axis_y <= 1'b0;
                state  <= S_AXIS;
              end
              default: ;
            endcase
          end
        end
        S_AXIS: begin
          cand    <= POS_W'(cand_n);
          fixed_c <= axis_y ? pos_x : POS_W'(pos_y);
          oob     <= cand_oob;
          hit     <= 1'b0;
          rd_cnt  <= '0;
          state   <= cand_oob ? S_APPLY : S_Q0;
        end
        S_Q0: begin
          qa0   <= div_quo;
          state <= S_Q1;
        end
        S_Q1: begin
          qa1   <= div_quo;
          state <= S_Q2;
        end
        S_Q2: begin
          qb0   <= div_quo;
          state <= S_Q3;
        end
        S_Q3: begin
          qb1   <= div_quo;
          state <= S_READ;
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == 2'd3) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (!axis_y) begin
            if (!(oob || hit)) begin
              pos_x <= cand;
            end
            x_blk  <= oob || hit;
            axis_y <= 1'b1;
            state  <= S_AXIS;
          end else begin
            if (!(oob || hit)) begin
              pos_y <= POSY_W'(cand);
            end
            res.y_blocked <= oob || hit;
            state         <= S_CAM;
          end
        end
        S_CAM: begin
          res.dot_x         <= pos_x;
          res.dot_y         <= pos_y;
          res.camera_x      <= cam_edge(pos_x, cfg.view_width, 14'(LEVEL_W));
          res.camera_y      <= POSY_W'(cam_edge(POS_W'(pos_y), POS_W'(cfg.view_height),
                                                14'(LEVEL_H)));
          res.x_blocked     <= x_blk;
          res.tile_rejected <= 1'b0;
          state             <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tile_map_collision_mover.sv =====
// Top level: stream ports, configuration registers and output word register.
// A tile write's word is registered in the mover and then in the output word register; a key
// event gives no word and leaves the mover ready for the next item. A tick runs per axis: setup,
// 4 reciprocal multiplies, 4 map reads, drain, apply (only setup and apply when the move leaves
// the level), then camera and output. The next item is taken once the word is handed on; sink stalls hold it.
// Reset loads the register defaults and zeroes position and velocity; the map is not cleared.
module tile_map_collision_mover (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // tile_index[7:0], tile_type[11:8], key_code[13:12],
                                // key_down[14], key_repeat[15]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // dot_x[10:0], dot_y[20:11], camera_x[31:21],
                                // camera_y[41:32], x_blocked[42], y_blocked[43],
                                // tile_rejected[44], zero[47:45]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmc_pkg::*;

  localparam logic [2:0] REG_VSTEP  = 3'd0;
  localparam logic [2:0] REG_VIEW_W = 3'd1;
  localparam logic [2:0] REG_VIEW_H = 3'd2;
  localparam logic [2:0] REG_WALL_F = 3'd3;
  localparam logic [2:0] REG_WALL_L = 3'd4;

  tmc_cfg_t cfg;
  tmc_in_t  in_item;
  tmc_res_t res;
  tmc_res_t out_word;
  logic     res_valid, res_ready;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.velocity_step   <= 5'd10;
      cfg.view_width      <= 11'd800;
      cfg.view_height     <= 10'd600;
      cfg.wall_first_type <= 4'd3;
      cfg.wall_last_type  <= 4'd11;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_VSTEP:  cfg.velocity_step   <= pwdata[4:0];
        REG_VIEW_W: cfg.view_width      <= pwdata[10:0];
        REG_VIEW_H: cfg.view_height     <= pwdata[9:0];
        REG_WALL_F: cfg.wall_first_type <= pwdata[3:0];
        REG_WALL_L: cfg.wall_last_type  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_VSTEP:  prdata = 32'(cfg.velocity_step);
      REG_VIEW_W: prdata = 32'(cfg.view_width);
      REG_VIEW_H: prdata = 32'(cfg.view_height);
      REG_WALL_F: prdata = 32'(cfg.wall_first_type);
      REG_WALL_L: prdata = 32'(cfg.wall_last_type);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    in_item.kind       = s_tuser;
    in_item.tile_index = s_tdata[7:0];
    in_item.tile_type  = s_tdata[11:8];
    in_item.key_code   = s_tdata[13:12];
    in_item.key_down   = s_tdata[14];
    in_item.key_repeat = s_tdata[15];
  end

  tmc_mover u_mover (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  assign m_tdata = {3'b0, out_word.tile_rejected, out_word.y_blocked, out_word.x_blocked,
                    out_word.camera_y, out_word.camera_x, out_word.dot_y, out_word.dot_x};

endmodule
